[rtl/core/utf8_byte_stream_decoder_defines.svh]
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder assertion macros
// Assertion helpers for the decoder's checker file.
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, quiet while reset is high
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Types, constants and helpers shared by the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CODE_W  = 32;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned LEFT_W  = 3;
   localparam int unsigned CONT_W  = 6;   // payload bits per continuation byte

   // Decoder state carried between bytes
   typedef struct packed {
      logic [CODE_W-1:0]  acc;
      logic [LEFT_W-1:0]  left;   // bytes still expected, zero = idle
      logic [COUNT_W-1:0] len;    // length of the open sequence
   } state_type;

   // Result of one decode step
   typedef struct packed {
      logic               emit;
      logic [CODE_W-1:0]  code_point;
      logic [COUNT_W-1:0] byte_count;
   } result_type;

   // Count of leading one bits, 0..8
   function automatic logic [COUNT_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
      logic [COUNT_W-1:0] n;
      logic               run;
      n   = '0;
      run = 1'b1;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         run = run & b[k];
         if (run) begin
            n = n + COUNT_W'(1);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[rtl/core/u8d_step.sv]
// ----------------------------------------------------------------------------
// u8d_step
// One decode step: lead byte classification and shift-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_step (
   input  u8d_pkg::state_type              state_q,
   input  logic [u8d_pkg::BYTE_W-1:0]      data_byte,
   input  logic                            is_last,
   output u8d_pkg::state_type              state_d,
   output u8d_pkg::result_type             result
);

   logic [u8d_pkg::COUNT_W-1:0] ones;
   logic [u8d_pkg::CODE_W-1:0]  acc_sh;
   logic [u8d_pkg::LEFT_W-1:0]  left_m1;
   logic [u8d_pkg::COUNT_W-1:0] ones_m1;
   logic [u8d_pkg::BYTE_W-1:0]  lead_bits;

   assign ones      = u8d_pkg::lead_ones(data_byte);
   assign acc_sh    = {state_q.acc[u8d_pkg::CODE_W-u8d_pkg::CONT_W-1:0],
                       data_byte[u8d_pkg::CONT_W-1:0]};
   assign left_m1   = state_q.left - u8d_pkg::LEFT_W'(1);
   assign ones_m1   = ones - u8d_pkg::COUNT_W'(1);
   // lead payload bits; a shift by eight leaves nothing
   assign lead_bits = data_byte & (u8d_pkg::BYTE_W'(8'hff) >> ones);

   always_comb begin
      state_d = state_q;
      result  = '0;
      if (state_q.left != '0) begin
         // continuation byte, not validated
         if (left_m1 == '0) begin
            result.emit       = 1'b1;
            result.code_point = acc_sh;
            result.byte_count = state_q.len;
            state_d           = '0;
         end else if (is_last) begin
            state_d = '0;     // truncated by end of buffer
         end else begin
            state_d.acc  = acc_sh;
            state_d.left = left_m1;
         end
      end else if (ones == u8d_pkg::COUNT_W'(0)) begin
         // plain ASCII
         result.emit       = 1'b1;
         result.code_point = u8d_pkg::CODE_W'(data_byte);
         result.byte_count = u8d_pkg::COUNT_W'(1);
         state_d           = '0;
      end else if (ones == u8d_pkg::COUNT_W'(1)) begin
         // stray continuation used as a lead: one byte, top bit dropped
         result.emit       = 1'b1;
         result.code_point = u8d_pkg::CODE_W'(data_byte[u8d_pkg::BYTE_W-2:0]);
         result.byte_count = u8d_pkg::COUNT_W'(1);
         state_d           = '0;
      end else if (is_last) begin
         state_d = '0;
      end else begin
         // open a multi-byte sequence
         state_d.acc  = u8d_pkg::CODE_W'(lead_bits);
         state_d.left = ones_m1[u8d_pkg::LEFT_W-1:0];
         state_d.len  = ones;
      end
   end

endmodule

`default_nettype wire

[rtl/core/utf8_byte_stream_decoder.sv]
// An accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the input register, one decode step and the
//   result register form a two-stage pipeline that advances whenever the result is free.
// Reset: synchronous, active high; clears both stage valids and the decode state.
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Streaming UTF-8 style decoder, one byte per beat, one code point per sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_byte_stream_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [u8d_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                             req_is_last,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [u8d_pkg::CODE_W-1:0]       rsp_code_point,
   output logic [u8d_pkg::COUNT_W-1:0]      rsp_byte_count
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [u8d_pkg::BYTE_W-1:0]    s1_byte_ff;
   logic                          s1_last_ff;
   u8d_pkg::state_type            state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [u8d_pkg::CODE_W-1:0]    rsp_code_ff;
   logic [u8d_pkg::COUNT_W-1:0]   rsp_count_ff;
   u8d_pkg::state_type            step_state;
   u8d_pkg::result_type           step_res;
   logic                          fire;
   logic                          in_beat;

   // decode of the byte held in the input register
   u8d_step u_step (
      .state_q   (state_ff),
      .data_byte (s1_byte_ff),
      .is_last   (s1_last_ff),
      .state_d   (step_state),
      .result    (step_res)
   );

   // pipeline control
   assign fire      = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | fire;
   assign in_beat   = req_valid & req_ready;

   always_comb begin
      s1_valid_in  = in_beat | (s1_valid_ff & ~fire);
      state_in     = fire ? step_state : state_ff;
      rsp_valid_in = fire ? step_res.emit : (rsp_valid_ff & ~rsp_ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_beat) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_is_last;
      end
      if (fire && step_res.emit) begin
         rsp_code_ff  <= step_res.code_point;
         rsp_count_ff <= step_res.byte_count;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_code_ff;
   assign rsp_byte_count = rsp_count_ff;

endmodule

`default_nettype wire

[rtl/core/u8d_checker.sv]
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks for the UTF-8 byte stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_byte_stream_decoder_defines.svh"

module u8d_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [u8d_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                             req_is_last,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [u8d_pkg::CODE_W-1:0]       rsp_code_point,
   input  logic [u8d_pkg::COUNT_W-1:0]      rsp_byte_count
);

   logic                                      req_stall;
   logic [u8d_pkg::BYTE_W:0]                  req_beat;
   logic                                      rsp_stall;
   logic [u8d_pkg::CODE_W+u8d_pkg::COUNT_W-1:0] rsp_beat;
   logic                                      count_ok;
   logic                                      single_beat;
   logic                                      code_narrow;

   assign req_stall   = req_valid & ~req_ready;
   assign req_beat    = {req_data_byte, req_is_last};
   assign rsp_stall   = rsp_valid & ~rsp_ready;
   assign rsp_beat    = {rsp_code_point, rsp_byte_count};
   assign count_ok    = (rsp_byte_count != '0) && (rsp_byte_count <= u8d_pkg::COUNT_W'(8));
   assign single_beat = rsp_valid && (rsp_byte_count == u8d_pkg::COUNT_W'(1));
   assign code_narrow = rsp_code_point[u8d_pkg::CODE_W-1:u8d_pkg::BYTE_W] == '0;

   // a stalled input beat holds
   `U8D_ASSERT_NEXT(a_req_hold, req_stall, req_valid && $stable(req_beat), "input beat moved")

   // a stalled result beat holds
   `U8D_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_beat), "result beat moved")

   // sequence lengths run from one to eight bytes
   `U8D_ASSERT_NOW(a_count_range, rsp_valid, count_ok, "byte count out of range")

   // one-byte codes never exceed a byte
   `U8D_ASSERT_NOW(a_single_width, single_beat, code_narrow, "one-byte code too wide")

   // a ready output never blocks the input side
   `U8D_ASSERT_NOW(a_no_stall, rsp_ready, req_ready, "input stalled with output ready")

endmodule

bind utf8_byte_stream_decoder u8d_checker u_chk (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: UTF-8 byte stream decoder testbench
// Feeds a directed table of byte beats (ASCII, lone continuation leads,
// long 7 and 8 byte leads, truncated buffers), then random well-formed
// sequences mixed with noise. Every accepted byte steps a local decoder
// model; each code point beat on rsp_ is checked against the oldest
// predicted code point.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int unsigned RANDOM_BYTES = 1450;
   localparam int unsigned DRAIN_AT     = 1000;  // sender waits for all results here
   localparam int unsigned QUIET_FIRST  = 300;   // sender: no idling in this byte range
   localparam int unsigned QUIET_LAST   = 500;
   localparam int          HOLD_START   = 600;   // receiver long hold-off, in cycles
   localparam int          HOLD_LEN     = 200;
   localparam int          RX_QUIET_LO  = 1200;  // receiver: no idling in this range
   localparam int          RX_QUIET_HI  = 1600;
   localparam int          DIRECTED_N   = 24;

   // One byte beat plus an optional typed-in expected code point
   typedef struct packed {
      logic [u8d_pkg::BYTE_W-1:0]  data;
      logic                        last;
      logic                        typed;
      logic [u8d_pkg::CODE_W-1:0]  code;
      logic [u8d_pkg::COUNT_W-1:0] count;
   } byte_beat_type;

   typedef struct packed {
      logic [u8d_pkg::CODE_W-1:0]  code;
      logic [u8d_pkg::COUNT_W-1:0] count;
   } code_point_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid     = 1'b0;
   logic                         req_ready;
   logic [u8d_pkg::BYTE_W-1:0]   req_data_byte = '0;
   logic                         req_is_last   = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready     = 1'b0;
   logic [u8d_pkg::CODE_W-1:0]   rsp_code_point;
   logic [u8d_pkg::COUNT_W-1:0]  rsp_byte_count;

   // Directed bytes; typed-in results only where obvious
   byte_beat_type directed_tbl [DIRECTED_N] = '{
      '{8'h00, 1'b0, 1'b1, 32'h0000_0000, 4'd1},   // ASCII low extreme
      '{8'h7f, 1'b0, 1'b1, 32'h0000_007f, 4'd1},   // ASCII high extreme
      '{8'h80, 1'b0, 1'b1, 32'h0000_0000, 4'd1},   // lone continuation lead
      '{8'hc3, 1'b0, 1'b0, 32'h0, 4'd0},           // two-byte sequence
      '{8'ha9, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'he2, 1'b1, 1'b0, 32'h0, 4'd0},           // lead cut by final byte
      '{8'he2, 1'b0, 1'b0, 32'h0, 4'd0},           // sequence cut mid-way
      '{8'h82, 1'b1, 1'b0, 32'h0, 4'd0},
      '{8'h41, 1'b0, 1'b1, 32'h0000_0041, 4'd1},   // fresh buffer after final
      '{8'hfe, 1'b0, 1'b0, 32'h0, 4'd0},           // seven-byte lead
      '{8'hbf, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'h80, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'hbf, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'h80, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'hbf, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'h80, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'hff, 1'b0, 1'b0, 32'h0, 4'd0},           // eight-byte lead, wraps
      '{8'hbf, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'hbf, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'hbf, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'hbf, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'hbf, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'hbf, 1'b0, 1'b0, 32'h0, 4'd0},
      '{8'hff, 1'b1, 1'b0, 32'h0, 4'd0}            // unchecked continuation, final
   };

   byte_beat_type  byte_stream [$];
   code_point_type pending_codes [$];

   // Decoder model state
   logic [u8d_pkg::CODE_W-1:0]  model_acc;
   logic [u8d_pkg::LEFT_W-1:0]  model_left;
   logic [u8d_pkg::COUNT_W-1:0] model_len;

   int  bytes_sent    = 0;
   int  codes_checked = 0;
   int  mismatches    = 0;
   int  rx_cycle      = 0;
   bit  stream_built  = 1'b0;
   bit  drained       = 1'b0;

   utf8_byte_stream_decoder i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_byte_count (rsp_byte_count)
   );

   task automatic report_mismatch(input string what,
                                  input logic [u8d_pkg::CODE_W-1:0] got,
                                  input logic [u8d_pkg::CODE_W-1:0] want);
      $display("mismatch %s at result %0d: got 0x%0h, want 0x%0h",
               what, codes_checked, got, want);
      mismatches++;
   endtask

   // Step the decoder model by one byte
   task automatic decode_byte(input logic [u8d_pkg::BYTE_W-1:0] b, input logic last,
                              output bit emit, output code_point_type res);
      int ones;
      emit = 1'b0;
      res  = '0;
      if (model_left != '0) begin
         model_acc  = (model_acc << u8d_pkg::CONT_W) +
                      u8d_pkg::CODE_W'(b[u8d_pkg::CONT_W-1:0]);
         model_left = model_left - u8d_pkg::LEFT_W'(1);
         if (model_left == '0) begin
            emit = 1'b1;
            res  = '{model_acc, model_len};
         end
         if (emit || last) begin
            model_acc = '0; model_left = '0; model_len = '0;
         end
      end else begin
         ones = 0;
         for (int k = u8d_pkg::BYTE_W - 1; k >= 0; k--) begin
            if (!b[k]) break;
            ones++;
         end
         if (ones == 0) begin
            emit = 1'b1;
            res  = '{u8d_pkg::CODE_W'(b), u8d_pkg::COUNT_W'(1)};
         end else if (ones == 1) begin
            emit = 1'b1;
            res  = '{u8d_pkg::CODE_W'(b[6:0]), u8d_pkg::COUNT_W'(1)};
         end else if (!last) begin
            model_acc  = (ones < 8) ? u8d_pkg::CODE_W'(b & (8'hff >> ones)) : '0;
            model_left = u8d_pkg::LEFT_W'(ones - 1);
            model_len  = u8d_pkg::COUNT_W'(ones);
         end
      end
   endtask

   function automatic void push_byte(input logic [u8d_pkg::BYTE_W-1:0] b,
                                     input logic last);
      byte_stream.push_back('{b, last, 1'b0, u8d_pkg::CODE_W'(0), u8d_pkg::COUNT_W'(0)});
   endfunction

   // Random part: mostly well-formed sequences, some cut short, some noise
   task automatic build_random_stream();
      int goal;
      int n;
      int cut;
      int pick;
      logic [u8d_pkg::BYTE_W-1:0] b;
      goal = byte_stream.size() + RANDOM_BYTES;
      while (byte_stream.size() < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)      n = 0;
            else if (pick < 35) n = 1;
            else if (pick < 80) n = $urandom_range(2, 4);
            else                n = $urandom_range(5, 8);
            cut = -1;
            if (n >= 2 && $urandom_range(0, 9) == 0) cut = $urandom_range(0, n - 2);
            // lead: n ones, a zero unless n is 8, random payload
            b = u8d_pkg::BYTE_W'((32'hff << (8 - n)) | ($urandom & (32'hff >> (n + 1))));
            if (cut == 0) begin
               push_byte(b, 1'b1);
            end else begin
               push_byte(b, (n <= 1) ? ($urandom_range(0, 99) < 15) : 1'b0);
               for (int k = 1; k < n; k++) begin
                  if ($urandom_range(0, 9) == 0) b = u8d_pkg::BYTE_W'($urandom);
                  else                          b = {2'b10, 6'($urandom)};
                  if (k == cut) begin
                     push_byte(b, 1'b1);
                     break;
                  end
                  push_byte(b, (k == n - 1) ? ($urandom_range(0, 99) < 15) : 1'b0);
               end
            end
         end else begin
            push_byte(u8d_pkg::BYTE_W'($urandom), $urandom_range(0, 9) == 0);
         end
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: random ready, one long hold-off, one stretch always ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_cycle  <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
            rsp_ready <= 1'b0;
         end else if (rx_cycle >= RX_QUIET_LO && rx_cycle < RX_QUIET_HI) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 20);
         end
      end
   end

   // Result check, prediction and byte driver
   always @(posedge clock) begin
      bit             emit;
      bit             hold;
      code_point_type predicted;
      code_point_type want;
      byte_beat_type  beat;
      if (reset) begin
         req_valid  <= 1'b0;
         model_acc  = '0;
         model_left = '0;
         model_len  = '0;
      end else begin
         // result beat against oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (pending_codes.size() == 0) begin
               report_mismatch("unexpected result", rsp_code_point, '0);
            end else begin
               want = pending_codes.pop_front();
               if (rsp_code_point !== want.code)
                  report_mismatch("code_point", rsp_code_point, want.code);
               if (rsp_byte_count !== want.count)
                  report_mismatch("byte_count", u8d_pkg::CODE_W'(rsp_byte_count),
                                  u8d_pkg::CODE_W'(want.count));
            end
            codes_checked++;
         end

         // accepted byte beat steps the model
         if (req_valid && req_ready) begin
            beat = byte_stream[bytes_sent];
            decode_byte(beat.data, beat.last, emit, predicted);
            if (beat.typed)  pending_codes.push_back('{beat.code, beat.count});
            else if (emit)   pending_codes.push_back(predicted);
            bytes_sent++;
         end

         // next byte beat
         if (!req_valid || req_ready) begin
            hold = 1'b0;
            if (bytes_sent == DRAIN_AT && !drained) begin
               if (pending_codes.size() != 0) hold = 1'b1;
               else                           drained = 1'b1;
            end
            if (!(bytes_sent >= QUIET_FIRST && bytes_sent < QUIET_LAST) &&
                $urandom_range(0, 99) < 20)
               hold = 1'b1;
            if (stream_built && bytes_sent < byte_stream.size() && !hold) begin
               req_valid     <= 1'b1;
               req_data_byte <= byte_stream[bytes_sent].data;
               req_is_last   <= byte_stream[bytes_sent].last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Run control
   initial begin
      reset = 1'b1;
      for (int i = 0; i < DIRECTED_N; i++) byte_stream.push_back(directed_tbl[i]);
      build_random_stream();
      stream_built = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (bytes_sent < byte_stream.size() || pending_codes.size() != 0);
      repeat (10) @(posedge clock);
      $display("Decoded %0d byte beats into %0d checked code points, %0d mismatches",
               bytes_sent, codes_checked, mismatches);
      $display("Covered ASCII, lone and long leads, truncated buffers, stalls and drain");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Timeout
   initial begin
      #2000000;
      $display("Timeout with %0d of %0d bytes sent, %0d results outstanding",
               bytes_sent, byte_stream.size(), pending_codes.size());
      $display("FAILURE");
      $finish;
   end

endmodule
